@@ sv/mbps_pkg.sv @@
// Shared types and constants of the masked byte pattern scan unit.
// Holds the beat structs, register and capture codes and the default sizes.
// Depends on nothing; every other file of the block imports it.
package mbps_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int COUNT_BITS_DEF  = 32;
	localparam int RFIFO_DEPTH     = 4;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_PATTERN_LENGTH = 3'd0;
	localparam cfg_index_t REG_ALIGN_LOG2     = 3'd1;
	localparam cfg_index_t REG_NTH_MATCH      = 3'd2;
	localparam cfg_index_t REG_MAX_RESULTS    = 3'd3;
	localparam cfg_index_t REG_BASE_ADDRESS   = 3'd4;
	localparam cfg_index_t REG_CAPTURE_KIND   = 3'd5;
	localparam cfg_index_t REG_CAPTURE_OFFSET = 3'd6;
	localparam cfg_index_t REG_USE_REL_TARGET = 3'd7;

	typedef logic [2:0] cap_kind_t;

	localparam cap_kind_t CAP_NONE  = 3'd0;
	localparam cap_kind_t CAP_REL8  = 3'd1;
	localparam cap_kind_t CAP_REL32 = 3'd2;
	localparam cap_kind_t CAP_U16   = 3'd3;
	localparam cap_kind_t CAP_U32   = 3'd4;
	localparam cap_kind_t CAP_U64   = 3'd5;

	localparam logic REQ_PATTERN = 1'b0;
	localparam logic REQ_DATA    = 1'b1;

	localparam logic RES_MATCH   = 1'b0;
	localparam logic RES_SUMMARY = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [4:0] pattern_index;
		logic [7:0] pattern_value;
		logic [7:0] pattern_mask;
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [63:0] match_address;
		logic [63:0] capture_value;
		logic [63:0] target_address;
		logic [31:0] match_count;
		logic        last;
	} result_t;

	// One queue entry covers every beat that one data byte causes.
	typedef struct packed {
		logic        has_match;
		logic        has_sum;
		logic [63:0] match_address;
		logic [63:0] capture_value;
		logic [63:0] target_address;
		logic [31:0] match_count;
	} rfifo_entry_t;

	// Number of bytes a capture kind reads; zero for no capture.
	function automatic logic [3:0] cap_size(input cap_kind_t kind);
		logic [3:0] size;
		unique case (kind)
			CAP_REL8:  size = 4'd1;
			CAP_REL32: size = 4'd4;
			CAP_U16:   size = 4'd2;
			CAP_U32:   size = 4'd4;
			CAP_U64:   size = 4'd8;
			default:   size = 4'd0;
		endcase
		return size;
	endfunction

endpackage

@@ sv/mbps_window_cmp.sv @@
// Masked compare of the pattern against the byte window, plus capture extraction.
// Purely combinational; uses mbps_pkg only for the default pattern size.
// Instantiated by masked_byte_pattern_scan_unit.
module mbps_window_cmp
	import mbps_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN_DEF + 1)
) (
	input  logic [MAX_PATTERN-1:0][7:0] win,
	input  logic [MAX_PATTERN-1:0][7:0] pval,
	input  logic [MAX_PATTERN-1:0][7:0] pmask,
	input  logic [LEN_W-1:0]            len,
	input  logic [4:0]                  cap_offset,
	input  logic [3:0]                  cap_len,
	output logic                        hit,
	output logic                        cap_ok,
	output logic [63:0]                 cap_raw
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0] diff;

	// Pattern entry p lines up with window byte MAX_PATTERN - len + p, so the
	// candidate always ends at the newest byte.
	always_comb begin
		for (int p = 0; p < MAX_PATTERN; p++) begin
			diff[p] = 1'b0;
			if (p < int'(len)) begin
				diff[p] = |((win[IDX_W'(MAX_PATTERN - int'(len) + p)] ^ pval[p]) & pmask[p]);
			end
		end
	end

	assign hit = ~|diff;

	always_comb begin
		int cidx;
		cap_raw = '0;
		for (int b = 0; b < 8; b++) begin
			cidx = MAX_PATTERN - int'(len) + int'(cap_offset) + b;
			if (b < int'(cap_len) && cidx < MAX_PATTERN) begin
				cap_raw[8*b +: 8] = win[IDX_W'(cidx)];
			end
		end
	end

	assign cap_ok = (cap_len != 4'd0) && (int'(cap_offset) + int'(cap_len) <= int'(len));

endmodule

@@ sv/mbps_rfifo.sv @@
// Small result queue between the scan pipeline and the result channel.
// Stores rfifo_entry_t from mbps_pkg; one push and one pop per cycle.
// Instantiated by masked_byte_pattern_scan_unit.
module mbps_rfifo
	import mbps_pkg::*;
#(
	parameter int DEPTH = RFIFO_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  rfifo_entry_t                 wdata,
	input  logic                         pop,
	output rfifo_entry_t                 rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rfifo_entry_t   mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

@@ sv/masked_byte_pattern_scan_unit.sv @@
// Masked byte pattern scan unit: top level with configuration, scan pipeline and output.
// Depends on mbps_pkg, mbps_window_cmp and mbps_rfifo.
//
// The unit takes one input beat per clock cycle, pattern entry writes and buffer data
// bytes alike, and keeps that rate as long as results are drained. A data byte is
// compared against the whole pattern at once, all pattern positions in parallel
// against the window of the newest MAX_PATTERN bytes. An accepted beat passes
// the input register, the compare and count stage, and the address stage that
// fills a four-entry result queue. The result channel moves one beat per cycle
// while result_ready is high; a final byte of a buffer that is also a reported
// match gives two beats (the match, then the summary), which is the only case
// where the output side sets the pace. Input ready drops only when the result
// queue together with the bytes still in flight could fill it. Configuration
// writes take effect at once and are meant for idle periods between buffers;
// pattern entries, in contrast, may be rewritten in the middle of a buffer and
// apply from the next data byte on.
module masked_byte_pattern_scan_unit
	import mbps_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,

	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,

	input  logic                   cfg_we,
	input  cfg_index_t             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int FCNT_W = $clog2(RFIFO_DEPTH + 1);

	// Everything the address stage needs from the compare stage.
	typedef struct packed {
		logic        has_match;
		logic        has_sum;
		logic [31:0] offset;
		logic [31:0] count;
		logic [63:0] cap_plain;
		logic        is_rel;
		logic [33:0] rel_disp;
	} s2_rec_t;

	// Configuration registers.
	logic [5:0]  cfg_len_q;
	logic [3:0]  cfg_align_q;
	logic [15:0] cfg_nth_q;
	logic [15:0] cfg_maxres_q;
	logic [63:0] cfg_base_q;
	cap_kind_t   cfg_capk_q;
	logic [4:0]  cfg_capoff_q;
	logic        cfg_userel_q;

	// Scan state.
	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [MAX_PATTERN-1:0][7:0] pval_q;
	logic [MAX_PATTERN-1:0][7:0] pmask_q;
	logic [31:0]                 seen_q;
	logic [COUNT_BITS-1:0]       found_q;
	logic [15:0]                 emitted_q;

	// Pipeline.
	logic    v1_q;
	item_t   item_s1;
	logic    v2_q;
	s2_rec_t rec_s2;
	logic    sub_q;

	logic                        item_acc;
	logic [LEN_W-1:0]            eff_len;
	logic [MAX_PATTERN-1:0][7:0] win_new;
	logic                        is_data;
	logic                        eob;
	logic                        candidate;
	logic [31:0]                 offset;
	logic [15:0]                 addr_lo;
	logic [15:0]                 amask;
	logic                        aligned;
	logic                        bytes_hit;
	logic                        match;
	logic                        counted;
	logic [COUNT_BITS-1:0]       found_inc;
	logic                        nth_ok;
	logic                        limit_hit;
	logic                        emit;
	logic [15:0]                 emitted_next;
	logic [31:0]                 count32;
	logic [3:0]                  cap_len;
	logic                        cap_ok;
	logic [63:0]                 cap_raw;
	logic                        is_rel;
	logic [33:0]                 disp;
	logic [33:0]                 rel_disp;

	logic [63:0]                 addr_s2;
	logic [63:0]                 tgt_s2;
	rfifo_entry_t                entry;
	rfifo_entry_t                head;
	logic [FCNT_W-1:0]           fifo_cnt;
	logic                        pop;
	logic                        sum_beat;

	// ------------------------------------------------------------------
	// Configuration port. Every index of the port names a register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q    <= 6'd1;
			cfg_align_q  <= '0;
			cfg_nth_q    <= '0;
			cfg_maxres_q <= '0;
			cfg_base_q   <= '0;
			cfg_capk_q   <= CAP_NONE;
			cfg_capoff_q <= '0;
			cfg_userel_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: cfg_len_q    <= cfg_data[5:0];
				REG_ALIGN_LOG2:     cfg_align_q  <= cfg_data[3:0];
				REG_NTH_MATCH:      cfg_nth_q    <= cfg_data[15:0];
				REG_MAX_RESULTS:    cfg_maxres_q <= cfg_data[15:0];
				REG_BASE_ADDRESS:   cfg_base_q   <= cfg_data;
				REG_CAPTURE_KIND:   cfg_capk_q   <= cfg_data[2:0];
				REG_CAPTURE_OFFSET: cfg_capoff_q <= cfg_data[4:0];
				REG_USE_REL_TARGET: cfg_userel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A length of zero acts as one, and anything above the window size is
	// clipped to the window size.
	always_comb begin
		if (cfg_len_q == 6'd0) begin
			eff_len = LEN_W'(1);
		end else if (int'(cfg_len_q) > MAX_PATTERN) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end else begin
			eff_len = LEN_W'(cfg_len_q);
		end
	end

	// ------------------------------------------------------------------
	// Input register. The pipeline behind it never stalls, so the only
	// thing that can hold off a new beat is room in the result queue: each
	// beat in flight may need one queue entry.
	// ------------------------------------------------------------------
	assign item_ready = (4'(fifo_cnt) + 4'(v1_q) + 4'(v2_q)) < 4'(RFIFO_DEPTH);
	assign item_acc   = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else begin
			v1_q <= item_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1 <= item;
		end
	end

	// ------------------------------------------------------------------
	// Compare and count stage.
	// ------------------------------------------------------------------
	assign is_data = v1_q && (item_s1.req_type == REQ_DATA);
	assign eob     = is_data && item_s1.end_of_buffer;

	// The window with the new byte shifted in at the top.
	always_comb begin
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_new[i] = win_q[i+1];
		end
		win_new[MAX_PATTERN-1] = item_s1.data_byte;
	end

	// A candidate exists once the buffer (since the last wrap of the byte
	// counter) holds at least the pattern length.
	assign candidate = ({1'b0, seen_q} + 33'd1) >= 33'(eff_len);
	assign offset    = seen_q + 32'd1 - 32'(eff_len);

	// Alignment only looks at the low bits of base plus offset.
	assign addr_lo = cfg_base_q[15:0] + offset[15:0];
	assign amask   = ~(16'hFFFF << cfg_align_q);
	assign aligned = (addr_lo & amask) == 16'd0;

	assign cap_len = cap_size(cfg_capk_q);

	mbps_window_cmp #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_cmp (
		.win        (win_new),
		.pval       (pval_q),
		.pmask      (pmask_q),
		.len        (eff_len),
		.cap_offset (cfg_capoff_q),
		.cap_len    (cap_len),
		.hit        (bytes_hit),
		.cap_ok     (cap_ok),
		.cap_raw    (cap_raw)
	);

	assign match     = is_data && candidate && aligned && bytes_hit;
	assign counted   = match && (found_q != '1);
	assign found_inc = found_q + COUNT_BITS'(counted);

	// With a match number set, only the match that just raised the count to
	// that number is reported; a saturated count never reports again.
	assign nth_ok    = (cfg_nth_q == 16'd0) ||
	                   (counted && (CMP_W'(found_inc) == CMP_W'(cfg_nth_q)));
	assign limit_hit = (cfg_maxres_q != 16'd0) && (emitted_q >= cfg_maxres_q);
	assign emit      = match && nth_ok && !limit_hit;

	assign emitted_next = (emit && (emitted_q != 16'hFFFF)) ? emitted_q + 16'd1 : emitted_q;

	// The reported count is clipped to 32 bits when the counter is wider.
	if (COUNT_BITS > 32) begin : g_cnt_sat
		assign count32 = (|found_inc[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : found_inc[31:0];
	end else begin : g_cnt_ext
		assign count32 = 32'(found_inc);
	end

	// Relative captures: the displacement is sign extended, and the target is
	// the match address plus capture offset plus capture size plus displacement.
	// The address-independent part is summed here.
	assign is_rel   = cap_ok && ((cfg_capk_q == CAP_REL8) || (cfg_capk_q == CAP_REL32));
	assign disp     = (cfg_capk_q == CAP_REL8) ? 34'(signed'(cap_raw[7:0]))
	                                           : 34'(signed'(cap_raw[31:0]));
	assign rel_disp = disp + 34'(cfg_capoff_q) + 34'(cap_len);

	// State update. The final byte of a buffer clears the buffer state after
	// its own results have been worked out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			pval_q    <= '0;
			pmask_q   <= '0;
			seen_q    <= '0;
			found_q   <= '0;
			emitted_q <= '0;
		end else if (v1_q) begin
			if (item_s1.req_type == REQ_PATTERN) begin
				if (int'(item_s1.pattern_index) < MAX_PATTERN) begin
					pval_q[IDX_W'(item_s1.pattern_index)]  <= item_s1.pattern_value;
					pmask_q[IDX_W'(item_s1.pattern_index)] <= item_s1.pattern_mask;
				end
			end else if (item_s1.end_of_buffer) begin
				win_q     <= '0;
				seen_q    <= '0;
				found_q   <= '0;
				emitted_q <= '0;
			end else begin
				win_q     <= win_new;
				seen_q    <= seen_q + 32'd1;
				found_q   <= found_inc;
				emitted_q <= emitted_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else begin
			v2_q <= emit || eob;
		end
	end

	always_ff @(posedge clk) begin
		if (emit || eob) begin
			rec_s2.has_match <= emit;
			rec_s2.has_sum   <= eob;
			rec_s2.offset    <= offset;
			rec_s2.count     <= count32;
			rec_s2.cap_plain <= cap_ok ? cap_raw : 64'd0;
			rec_s2.is_rel    <= is_rel;
			rec_s2.rel_disp  <= rel_disp;
		end
	end

	// ------------------------------------------------------------------
	// Address stage: full 64-bit match address and relative target, then
	// into the result queue.
	// ------------------------------------------------------------------
	assign addr_s2 = cfg_base_q + 64'(rec_s2.offset);
	assign tgt_s2  = cfg_base_q + 64'(rec_s2.offset) + 64'(signed'(rec_s2.rel_disp));

	always_comb begin
		entry.has_match      = rec_s2.has_match;
		entry.has_sum        = rec_s2.has_sum;
		entry.match_address  = addr_s2;
		entry.capture_value  = rec_s2.is_rel ? tgt_s2 : rec_s2.cap_plain;
		entry.target_address = (rec_s2.is_rel && cfg_userel_q) ? tgt_s2 : 64'd0;
		entry.match_count    = rec_s2.count;
	end

	mbps_rfifo #(
		.DEPTH (RFIFO_DEPTH)
	) u_rfifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v2_q),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.count  (fifo_cnt)
	);

	// ------------------------------------------------------------------
	// Output side. An entry holding both a match and a summary is sent as
	// two beats; sub_q marks that the match beat has already gone out.
	// ------------------------------------------------------------------
	assign result_valid = fifo_cnt != '0;
	assign sum_beat     = !head.has_match || sub_q;

	always_comb begin
		result.result_kind    = sum_beat ? RES_SUMMARY : RES_MATCH;
		result.match_address  = sum_beat ? 64'd0 : head.match_address;
		result.capture_value  = sum_beat ? 64'd0 : head.capture_value;
		result.target_address = sum_beat ? 64'd0 : head.target_address;
		result.match_count    = head.match_count;
		result.last           = sum_beat || !head.has_sum;
	end

	assign pop = result_valid && result_ready && result.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (result_valid && result_ready) begin
			sub_q <= !result.last;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q |-> (fifo_cnt < FCNT_W'(RFIFO_DEPTH)))
		else $error("result queue written while full");

	a_eob_clears: assert property (@(posedge clk) disable iff (!arst_n)
		eob |=> (seen_q == 32'd0 && found_q == '0 && emitted_q == 16'd0))
		else $error("buffer state not cleared after end of buffer");

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (head.has_match || head.has_sum))
		else $error("result queue holds an entry without any beat");

	a_sub_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (result_valid && head.has_match && head.has_sum))
		else $error("second beat pending on an entry that has no summary");

endmodule

@@ test/masked_byte_pattern_scan_unit_test.sv @@
// Self-checking testbench of the masked byte pattern scan unit.
// Predicts every match report and buffer summary from the accepted beats and checks them.
// Depends on mbps_pkg and the masked_byte_pattern_scan_unit RTL.
module masked_byte_pattern_scan_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mbps_pkg::*;

	localparam int unsigned SIG_BYTES      = MAX_PATTERN_DEF;
	// Two pipeline stages ahead of the result queue, plus margin.
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned END_CYCLES     = 20;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned MAX_REPORTS    = 10;

	// Software copy of the register file, at the register widths.
	typedef struct packed {
		logic [5:0]  pattern_length;
		logic [3:0]  align_log2;
		logic [15:0] nth_match;
		logic [15:0] max_results;
		logic [63:0] base_address;
		cap_kind_t   capture_kind;
		logic [4:0]  capture_offset;
		logic        use_relative_target;
	} scan_cfg_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_we       = 1'b0;
	cfg_index_t            cfg_index    = REG_PATTERN_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Predictor state: the byte window, the signature and the per-buffer counters.
	logic [7:0]  win_bytes [SIG_BYTES];
	logic [7:0]  sig_value [SIG_BYTES];
	logic [7:0]  sig_mask  [SIG_BYTES];
	logic [31:0] bytes_in_buffer;
	logic [31:0] hit_count;
	logic [15:0] hits_reported;
	scan_cfg_t   cfg_now;

	// Match reports and summaries that the unit still owes, oldest first.
	result_t     scan_results_due [$];

	int unsigned send_idle_pct = 26;
	int unsigned recv_idle_pct = 79;
	int unsigned beats_sent    = 0;
	int unsigned mismatch_count = 0;
	int unsigned stall_cycles  = 0;

	masked_byte_pattern_scan_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic scan_cfg_t reset_config();
		scan_cfg_t c;
		c = '0;
		c.pattern_length = 6'd1;
		return c;
	endfunction

	// Number of signature bytes really compared: zero acts as one, and anything
	// past the window size is clipped to it.
	function automatic int unsigned sig_len();
		if (cfg_now.pattern_length == 6'd0)
			return 1;
		if (cfg_now.pattern_length > SIG_BYTES)
			return SIG_BYTES;
		return int'(cfg_now.pattern_length);
	endfunction

	// Works out the beats that one accepted item causes and queues them. Pattern
	// writes only touch the signature; a data byte shifts the window, tests the
	// candidate that ends on it, and on the final byte adds the summary.
	task automatic predict_scan_results(input item_t it);
		int unsigned len, first, size, p;
		logic [31:0] prior, offset32;
		logic [63:0] addr, amask, cap, disp, tgt;
		logic        hit, counted, emit, have_hit;
		result_t     hit_beat, sum_beat;
		have_hit = 1'b0;
		hit_beat = '0;
		if (it.req_type == REQ_PATTERN) begin
			sig_value[it.pattern_index] = it.pattern_value;
			sig_mask[it.pattern_index]  = it.pattern_mask;
			return;
		end
		for (p = 0; p < SIG_BYTES - 1; p++)
			win_bytes[p] = win_bytes[p + 1];
		win_bytes[SIG_BYTES - 1] = it.data_byte;
		len = sig_len();
		prior = bytes_in_buffer;
		bytes_in_buffer = prior + 32'd1;
		first = SIG_BYTES - len;
		// A candidate only exists once a full signature length of this buffer is in.
		if (64'(prior) + 64'd1 >= 64'(len)) begin
			offset32 = prior + 32'd1 - 32'(len);
			addr = cfg_now.base_address + 64'(offset32);
			amask = (64'd1 << cfg_now.align_log2) - 64'd1;
			hit = ((addr & amask) == 64'd0);
			for (p = 0; p < len; p++)
				if ((win_bytes[first + p] & sig_mask[p]) != (sig_value[p] & sig_mask[p]))
					hit = 1'b0;
			if (hit) begin
				counted = (hit_count != 32'hFFFF_FFFF);
				if (counted)
					hit_count = hit_count + 32'd1;
				// With nth_match set, only the hit that brought the count to it is reported.
				emit = (cfg_now.nth_match == 16'd0) ||
					(counted && hit_count == 32'(cfg_now.nth_match));
				if (cfg_now.max_results != 16'd0 && hits_reported >= cfg_now.max_results)
					emit = 1'b0;
				if (emit) begin
					if (hits_reported != 16'hFFFF)
						hits_reported = hits_reported + 16'd1;
					case (cfg_now.capture_kind) inside
						CAP_REL8: size = 1;
						CAP_REL32, CAP_U32: size = 4;
						CAP_U16: size = 2;
						CAP_U64: size = 8;
						default: size = 0;
					endcase
					cap = 64'd0;
					tgt = 64'd0;
					// A capture reaching past the signature end counts as no capture.
					if (size != 0 && cfg_now.capture_offset + size <= len) begin
						for (p = 0; p < size; p++)
							cap |= 64'(win_bytes[first + cfg_now.capture_offset + p]) << (8 * p);
						if (cfg_now.capture_kind == CAP_REL8 ||
							cfg_now.capture_kind == CAP_REL32) begin
							if (cfg_now.capture_kind == CAP_REL8)
								disp = {{56{cap[7]}}, cap[7:0]};
							else
								disp = {{32{cap[31]}}, cap[31:0]};
							cap = addr + 64'(cfg_now.capture_offset) + 64'(size) + disp;
							if (cfg_now.use_relative_target)
								tgt = cap;
						end
					end
					hit_beat.result_kind    = RES_MATCH;
					hit_beat.match_address  = addr;
					hit_beat.capture_value  = cap;
					hit_beat.target_address = tgt;
					hit_beat.match_count    = hit_count;
					have_hit = 1'b1;
				end
			end
		end
		if (have_hit) begin
			hit_beat.last = !it.end_of_buffer;
			scan_results_due.insert(scan_results_due.size(), hit_beat);
		end
		if (it.end_of_buffer) begin
			sum_beat = '0;
			sum_beat.result_kind = RES_SUMMARY;
			sum_beat.match_count = hit_count;
			sum_beat.last = 1'b1;
			scan_results_due.insert(scan_results_due.size(), sum_beat);
			for (p = 0; p < SIG_BYTES; p++)
				win_bytes[p] = 8'd0;
			bytes_in_buffer = '0;
			hit_count = '0;
			hits_reported = '0;
		end
	endtask

	// Unused fields of a beat carry random bits so that every input bit toggles.
	function automatic item_t pattern_write(input logic [4:0] idx, input logic [7:0] v,
		input logic [7:0] m);
		item_t it;
		it.req_type      = REQ_PATTERN;
		it.pattern_index = idx;
		it.pattern_value = v;
		it.pattern_mask  = m;
		it.data_byte     = 8'($urandom);
		it.end_of_buffer = 1'($urandom);
		return it;
	endfunction

	function automatic item_t data_beat(input logic [7:0] b, input logic eob);
		item_t it;
		it.req_type      = REQ_DATA;
		it.pattern_index = 5'($urandom);
		it.pattern_value = 8'($urandom);
		it.pattern_mask  = 8'($urandom);
		it.data_byte     = b;
		it.end_of_buffer = eob;
		return it;
	endfunction

	function automatic logic [7:0] pick_mask();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'hFF;
		if (r < 85)
			return 8'($urandom);
		return 8'h00;
	endfunction

	// Presents one beat and holds it until accepted. Valid stays high into the next
	// beat unless an idle gap is drawn, so it is never lowered and raised in one step.
	task automatic send_beat(input item_t it);
		int unsigned gap;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		predict_scan_results(it);
		beats_sent++;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends a whole buffer, marking the final byte, with an occasional stray
	// pattern write slipped in between bytes.
	task automatic send_buffer(input logic [7:0] seq [$], input int unsigned noise_pct);
		int unsigned i;
		for (i = 0; i < seq.size(); i++) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(pattern_write(5'($urandom), 8'($urandom), pick_mask()));
			send_beat(data_beat(seq[i], i == seq.size() - 1));
		end
	endtask

	// Lets the unit run dry: no beat offered, nothing owed, and the pipeline
	// given time to finish bytes that produce no result.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (scan_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Writes all eight registers back to back while the unit is idle.
	task automatic apply_config(input scan_cfg_t c);
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 64'(c.pattern_length));
		write_reg(REG_ALIGN_LOG2, 64'(c.align_log2));
		write_reg(REG_NTH_MATCH, 64'(c.nth_match));
		write_reg(REG_MAX_RESULTS, 64'(c.max_results));
		write_reg(REG_BASE_ADDRESS, c.base_address);
		write_reg(REG_CAPTURE_KIND, 64'(c.capture_kind));
		write_reg(REG_CAPTURE_OFFSET, 64'(c.capture_offset));
		write_reg(REG_USE_REL_TARGET, 64'(c.use_relative_target));
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	// Mostly short signatures and plain settings so that hits are frequent, with
	// the register extremes and the out-of-range codes mixed in now and then.
	function automatic scan_cfg_t random_config();
		scan_cfg_t   c;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			c.pattern_length = 6'($urandom_range(1, 6));
		else if (r < 80)
			c.pattern_length = 6'($urandom_range(7, 31));
		else if (r < 88)
			c.pattern_length = 6'(SIG_BYTES);
		else if (r < 94)
			c.pattern_length = 6'd0;
		else
			c.pattern_length = 6'($urandom_range(33, 63));
		r = $urandom_range(99);
		if (r < 70)
			c.align_log2 = 4'd0;
		else if (r < 90)
			c.align_log2 = 4'($urandom_range(1, 3));
		else
			c.align_log2 = 4'($urandom_range(4, 15));
		r = $urandom_range(99);
		c.nth_match = (r < 70) ? 16'd0 : (r < 95) ? 16'($urandom_range(1, 4)) : 16'hFFFF;
		r = $urandom_range(99);
		c.max_results = (r < 70) ? 16'd0 : (r < 95) ? 16'($urandom_range(1, 3)) : 16'hFFFF;
		case ($urandom_range(3))
			0: c.base_address = 64'd0;
			1: c.base_address = {$urandom, $urandom};
			2: c.base_address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(64));
			default: c.base_address = 64'($urandom_range(65535));
		endcase
		c.capture_kind = cap_kind_t'($urandom_range(7));
		c.capture_offset = ($urandom_range(99) < 75) ? 5'($urandom_range(7)) : 5'($urandom);
		c.use_relative_target = 1'($urandom);
		return c;
	endfunction

	// Result side: ready drops at random, then every accepted beat is checked
	// against the oldest owed beat.
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		result_t want;
		logic    bad;
		if (arst_n && result_valid && result_ready) begin
			if (scan_results_due.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("unexpected beat: kind=%0b addr=%h cap=%h tgt=%h count=%0d last=%0b",
						result.result_kind, result.match_address, result.capture_value,
						result.target_address, result.match_count, result.last);
				mismatch_count++;
			end else begin
				want = scan_results_due.pop_front();
				bad = (result.result_kind !== want.result_kind) ||
					(result.match_address !== want.match_address) ||
					(result.capture_value !== want.capture_value) ||
					(result.target_address !== want.target_address) ||
					(result.match_count !== want.match_count) ||
					(result.last !== want.last);
				if (bad) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("mismatch at %0t", $realtime);
						$display("  expected kind=%0b addr=%h cap=%h tgt=%h count=%0d last=%0b",
							want.result_kind, want.match_address, want.capture_value,
							want.target_address, want.match_count, want.last);
						$display("  actual   kind=%0b addr=%h cap=%h tgt=%h count=%0d last=%0b",
							result.result_kind, result.match_address, result.capture_value,
							result.target_address, result.match_count, result.last);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no beat moving on either side and no
	// register write means the unit has hung.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Reset state: length one and all masks zero, so every byte is a hit. The
	// final byte is a hit too, which gives a report followed by the summary.
	task automatic test_reset_defaults();
		send_buffer('{8'h00, 8'hFF}, 0);
	endtask

	// Length zero acts as one; the largest alignment lets only the first byte of a
	// base near the top of the address space through.
	task automatic test_length_and_alignment();
		scan_cfg_t c;
		c = reset_config();
		c.pattern_length = 6'd0;
		c.align_log2 = 4'hF;
		c.base_address = 64'hFFFF_FFFF_FFFF_8000;
		apply_config(c);
		send_buffer('{8'hA5, 8'h5A}, 0);
	endtask

	// An eight byte wildcard signature: no candidate until the eighth byte, which
	// then carries the whole window as a little-endian u64.
	task automatic test_u64_capture();
		scan_cfg_t c;
		c = reset_config();
		c.pattern_length = 6'd8;
		c.capture_kind = CAP_U64;
		apply_config(c);
		send_buffer('{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hFF}, 0);
	endtask

	// rel8 targets with the most negative and most positive displacement, also
	// reported as the target address.
	task automatic test_relative_captures();
		scan_cfg_t c;
		c = reset_config();
		c.pattern_length = 6'd2;
		c.capture_kind = CAP_REL8;
		c.capture_offset = 5'd1;
		c.use_relative_target = 1'b1;
		c.base_address = 64'h1000;
		apply_config(c);
		send_buffer('{8'h00, 8'h80, 8'h7F}, 0);
	endtask

	// Partial masks, the top entry index, only the second hit reported, then a
	// one-report limit with a capture that falls outside the signature and a
	// pattern rewrite that takes effect in the middle of a buffer.
	task automatic test_pattern_entries_and_limits();
		scan_cfg_t c;
		send_beat(pattern_write(5'd0, 8'h5A, 8'hF0));
		send_beat(pattern_write(5'd31, 8'hFF, 8'hFF));
		c = reset_config();
		c.nth_match = 16'd2;
		apply_config(c);
		send_buffer('{8'h50, 8'h5F, 8'h40, 8'h5A}, 0);
		c = reset_config();
		c.max_results = 16'd1;
		c.capture_kind = CAP_REL32;
		apply_config(c);
		send_beat(data_beat(8'h50, 1'b0));
		send_beat(pattern_write(5'd0, 8'h00, 8'h00));
		send_beat(data_beat(8'h00, 1'b1));
	endtask

	// Random scans: a fresh configuration and signature, then a few buffers in
	// which copies of the signature (masked-off bits random, some cut short) are
	// buried in random bytes.
	task automatic test_random_scan(input int unsigned quota, input int unsigned s_pct,
		input int unsigned r_pct);
		int unsigned stop_at, len, i, n, k;
		logic [7:0]  seq [$];
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at = beats_sent + quota;
		while (beats_sent < stop_at) begin
			apply_config(random_config());
			len = sig_len();
			for (i = 0; i < len; i++)
				send_beat(pattern_write(5'(i), 8'($urandom), pick_mask()));
			if ($urandom_range(99) < 30)
				send_beat(pattern_write(5'($urandom), 8'($urandom), pick_mask()));
			repeat ($urandom_range(1, 3)) begin
				seq.delete();
				n = ($urandom_range(99) < 85) ? $urandom_range(1, 40) : $urandom_range(41, 96);
				while (seq.size() < n) begin
					if ($urandom_range(99) < 40) begin
						k = ($urandom_range(99) < 80) ? len : $urandom_range(len - 1);
						for (i = 0; i < k; i++)
							seq.insert(seq.size(), (sig_value[i] & sig_mask[i]) |
								(8'($urandom) & ~sig_mask[i]));
					end else begin
						seq.insert(seq.size(), 8'($urandom));
					end
				end
				send_buffer(seq, 3);
			end
		end
	endtask

	initial begin
		cfg_now = reset_config();
		for (int i = 0; i < SIG_BYTES; i++) begin
			win_bytes[i] = 8'd0;
			sig_value[i] = 8'd0;
			sig_mask[i]  = 8'd0;
		end
		bytes_in_buffer = '0;
		hit_count = '0;
		hits_reported = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_length_and_alignment();
		test_u64_capture();
		test_relative_captures();
		test_pattern_entries_and_limits();

		// Slow receiver, then slow sender, then both at full rate.
		test_random_scan(400, 26, 79);
		test_random_scan(400, 79, 26);
		test_random_scan(400, 0, 0);

		item_valid <= 1'b0;
		while (scan_results_due.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && scan_results_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
